// ===== src/form_factor_stream_unit_defines.svh =====
// Assertion helpers shared by the form factor stream unit.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef FORM_FACTOR_STREAM_UNIT_DEFINES_SVH
`define FORM_FACTOR_STREAM_UNIT_DEFINES_SVH

`define FFS_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error(msg);

`define FFS_ASSERT_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/ffs_pkg.sv =====
`default_nettype none
package ffs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned K_W             = 5;
  localparam int unsigned K_MAX           = 18;
  localparam int unsigned DIV_W           = 128;
  localparam int unsigned QUO_W           = 16;

  localparam logic [33:0] NEAR_LIMIT_SQ   = 34'd4295;
  localparam logic [20:0] NUM_SCALE       = 21'd1600000;
  localparam logic [18:0] PI_SCALED       = 19'd314159;
  localparam logic [16:0] FF_ONE          = 17'd65536;
  localparam logic signed [15:0] NORM_Z_RESET = 16'sd16384;

  typedef enum logic [1:0] {
    REASON_OK   = 2'd0,
    REASON_NEAR = 2'd1,
    REASON_BACK = 2'd2
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_NORM_X = 3'd3,
    REG_NORM_Y = 3'd4,
    REG_NORM_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } cfg_t;

  // One classified target as it travels from the front to the back.
  typedef struct packed {
    logic signed [15:0] e_x;
    logic signed [15:0] e_y;
    logic signed [15:0] e_z;
    logic signed [15:0] nb_x;
    logic signed [15:0] nb_y;
    logic signed [15:0] nb_z;
    logic [K_W-1:0]     k;
    logic [31:0]        area;
    reason_e            reason;
    logic               last;
  } work_t;

endpackage
`default_nettype wire

// ===== src/ffs_if.sv =====
`default_nettype none
interface ffs_tgt_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] target_pos_x;
  logic signed [31:0] target_pos_y;
  logic signed [31:0] target_pos_z;
  logic signed [15:0] target_norm_x;
  logic signed [15:0] target_norm_y;
  logic signed [15:0] target_norm_z;
  logic [31:0]        target_area;
  logic               last_in;

  modport source (output valid, target_pos_x, target_pos_y, target_pos_z, target_norm_x,
                  target_norm_y, target_norm_z, target_area, last_in, input ready);
  modport sink (input valid, target_pos_x, target_pos_y, target_pos_z, target_norm_x,
                target_norm_y, target_norm_z, target_area, last_in, output ready);
endinterface

interface ffs_res_if ();
  logic        valid;
  logic        ready;
  logic [16:0] form_factor;
  logic [1:0]  reject_reason;
  logic        last_out;

  modport source (output valid, form_factor, reject_reason, last_out, input ready);
  modport sink (input valid, form_factor, reject_reason, last_out, output ready);
endinterface

interface ffs_cfg_if import ffs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ffs_front.sv =====
`default_nettype none
module ffs_front import ffs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ffs_tgt_if.sink          tgt_i,
  input  cfg_t             cfg_i,
  input  logic [CNT_W-1:0] q_count_i,
  output logic             push_o,
  output work_t            push_data_o
);

  logic v1_q, v2_q, v3_q;
  logic [CNT_W+1:0] used;
  logic accept;

  // Every transaction in the front already owns a queue slot, so the front never stalls.
  assign used = (CNT_W + 2)'(q_count_i) + (CNT_W + 2)'(v1_q) + (CNT_W + 2)'(v2_q)
              + (CNT_W + 2)'(v3_q);
  assign tgt_i.ready = used < (CNT_W + 2)'(QUEUE_DEPTH);
  assign accept = tgt_i.valid && tgt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic signed [15:0] na [3];
  assign na[0] = cfg_i.norm_x;
  assign na[1] = cfg_i.norm_y;
  assign na[2] = cfg_i.norm_z;

  // Stage 1: direction from source to target.
  logic signed [32:0] d1_q [3];
  logic signed [15:0] nb1_q [3];
  logic [31:0]        area1_q;
  logic               last1_q;

  always_ff @(posedge clk_i) begin
    d1_q[0]  <= 33'(tgt_i.target_pos_x) - 33'(cfg_i.pos_x);
    d1_q[1]  <= 33'(tgt_i.target_pos_y) - 33'(cfg_i.pos_y);
    d1_q[2]  <= 33'(tgt_i.target_pos_z) - 33'(cfg_i.pos_z);
    nb1_q[0] <= tgt_i.target_norm_x;
    nb1_q[1] <= tgt_i.target_norm_y;
    nb1_q[2] <= tgt_i.target_norm_z;
    area1_q  <= tgt_i.target_area;
    last1_q  <= tgt_i.last_in;
  end

  // Stage 2: magnitudes, exact cosine products and short-range squares.
  logic [32:0]        mag1 [3];
  logic [32:0]        m1;
  logic signed [32:0] d2_q [3];
  logic [32:0]        mag2_q [3];
  logic [32:0]        m2_q;
  logic signed [48:0] pa2_q [3];
  logic signed [48:0] pb2_q [3];
  logic [31:0]        sq2_q [3];
  logic signed [15:0] nb2_q [3];
  logic [31:0]        area2_q;
  logic               last2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
    end
    m1 = mag1[0];
    if (mag1[1] > m1) begin
      m1 = mag1[1];
    end
    if (mag1[2] > m1) begin
      m1 = mag1[2];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d2_q[i]   <= d1_q[i];
      mag2_q[i] <= mag1[i];
      pa2_q[i]  <= 49'(na[i]) * 49'(d1_q[i]);
      pb2_q[i]  <= 49'(nb1_q[i]) * 49'(d1_q[i]);
      sq2_q[i]  <= 32'(mag1[i][15:0]) * 32'(mag1[i][15:0]);
      nb2_q[i]  <= nb1_q[i];
    end
    m2_q    <= m1;
    area2_q <= area1_q;
    last2_q <= last1_q;
  end

  // Stage 3: classify, then reduce the direction to 16 bits for the back.
  logic signed [50:0] a2, b2;
  logic [33:0]        sqsum2;
  logic               near2;
  logic [K_W-1:0]     k2;
  logic [14:0]        qv2 [3];
  logic [15:0]        e2 [3];
  reason_e            reason2;
  work_t              w3_q;

  always_comb begin
    a2 = 51'(pa2_q[0]) + 51'(pa2_q[1]) + 51'(pa2_q[2]);
    b2 = -(51'(pb2_q[0]) + 51'(pb2_q[1]) + 51'(pb2_q[2]));
    sqsum2 = 34'(sq2_q[0]) + 34'(sq2_q[1]) + 34'(sq2_q[2]);
    // The squares only see the low half, which is exact while the largest term is short.
    near2 = (m2_q < 33'd65536) && (sqsum2 < NEAR_LIMIT_SQ);
    if (near2) begin
      reason2 = REASON_NEAR;
    end else if (a2 <= 0 || b2 <= 0) begin
      reason2 = REASON_BACK;
    end else begin
      reason2 = REASON_OK;
    end
    k2 = K_W'(K_MAX);
    for (int j = K_MAX; j >= 0; j--) begin
      if ((m2_q >> j) < 33'd32768) begin
        k2 = K_W'(j);
      end
    end
    for (int i = 0; i < 3; i++) begin
      qv2[i] = 15'(mag2_q[i] >> k2);
      e2[i]  = d2_q[i][32] ? 16'(-{1'b0, qv2[i]}) : {1'b0, qv2[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    w3_q.e_x    <= e2[0];
    w3_q.e_y    <= e2[1];
    w3_q.e_z    <= e2[2];
    w3_q.nb_x   <= nb2_q[0];
    w3_q.nb_y   <= nb2_q[1];
    w3_q.nb_z   <= nb2_q[2];
    w3_q.k      <= k2;
    w3_q.area   <= area2_q;
    w3_q.reason <= reason2;
    w3_q.last   <= last2_q;
  end

  assign push_o      = v3_q;
  assign push_data_o = w3_q;

endmodule
`default_nettype wire

// ===== src/ffs_queue.sv =====
`default_nettype none
`include "form_factor_stream_unit_defines.svh"
module ffs_queue import ffs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  work_t            push_data_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output work_t            head_o,
  output logic [CNT_W-1:0] count_o
);

  work_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  `FFS_ASSERT_NEVER(a_queue_overflow, push_i && count_q == CNT_W'(QUEUE_DEPTH), "queue overflow")
  `FFS_ASSERT_NEVER(a_queue_underflow, pop_i && count_q == '0, "queue underflow")

endmodule
`default_nettype wire

// ===== src/ffs_back.sv =====
`default_nettype none
`include "form_factor_stream_unit_defines.svh"
module ffs_back import ffs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     head_valid_i,
  input  work_t    head_i,
  output logic     pop_o,
  ffs_res_if.source res_o
);

  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned NSTG      = 5 + DIV_STEPS + 1;

  logic [NSTG-1:0] vld_q;
  logic            en;

  // The whole back pipeline moves as one; the last stage is the output register.
  assign en    = !vld_q[NSTG-1] || res_o.ready;
  assign pop_o = en && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], pop_o};
    end
  end

  logic signed [15:0] na [3];
  logic signed [15:0] e0 [3];
  logic signed [15:0] nb0 [3];
  logic [15:0]        qa0 [3];
  assign na[0]  = cfg_i.norm_x;
  assign na[1]  = cfg_i.norm_y;
  assign na[2]  = cfg_i.norm_z;
  assign e0[0]  = head_i.e_x;
  assign e0[1]  = head_i.e_y;
  assign e0[2]  = head_i.e_z;
  assign nb0[0] = head_i.nb_x;
  assign nb0[1] = head_i.nb_y;
  assign nb0[2] = head_i.nb_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qa0[i] = e0[i][15] ? 16'(-e0[i]) : 16'(e0[i]);
    end
  end

  // Stage 1: reduced cosine products and squares.
  logic signed [31:0] pa1_q [3];
  logic signed [31:0] pb1_q [3];
  logic [29:0]        q21_q [3];
  logic [31:0]        area1_q;
  logic [K_W-1:0]     k1_q;
  reason_e            rsn1_q;
  logic               last1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa1_q[i] <= 32'(na[i]) * 32'(e0[i]);
        pb1_q[i] <= 32'(nb0[i]) * 32'(e0[i]);
        q21_q[i] <= 30'(qa0[i][14:0]) * 30'(qa0[i][14:0]);
      end
      area1_q <= head_i.area;
      k1_q    <= head_i.k;
      rsn1_q  <= head_i.reason;
      last1_q <= head_i.last;
    end
  end

  // Stage 2: sums, clamped cosines and the scaled area.
  logic signed [33:0] ar1, br1;
  logic [31:0]        ua2_q, ub2_q, s2_q;
  logic [52:0]        ap2_q;
  logic [K_W-1:0]     k2_q;
  reason_e            rsn2_q;
  logic               last2_q;

  assign ar1 = 34'(pa1_q[0]) + 34'(pa1_q[1]) + 34'(pa1_q[2]);
  assign br1 = -(34'(pb1_q[0]) + 34'(pb1_q[1]) + 34'(pb1_q[2]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua2_q   <= (ar1 > 0) ? ar1[31:0] : '0;
      ub2_q   <= (br1 > 0) ? br1[31:0] : '0;
      s2_q    <= 32'(34'(q21_q[0]) + 34'(q21_q[1]) + 34'(q21_q[2]));
      ap2_q   <= 53'(area1_q) * 53'(NUM_SCALE);
      k2_q    <= k1_q;
      rsn2_q  <= rsn1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3: cosine product and squared length squared.
  logic [63:0]    p13_q, ss3_q;
  logic [52:0]    ap3_q;
  logic [K_W-1:0] k3_q;
  reason_e        rsn3_q;
  logic           last3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p13_q   <= 64'(ua2_q) * 64'(ub2_q);
      ss3_q   <= 64'(s2_q) * 64'(s2_q);
      ap3_q   <= ap2_q;
      k3_q    <= k2_q;
      rsn3_q  <= rsn2_q;
      last3_q <= last2_q;
    end
  end

  // Stage 4: 32-bit partial products of numerator and denominator.
  logic [63:0]    n00_q, n01_q, n10_q, n11_q;
  logic [50:0]    dl4_q, dh4_q;
  logic [K_W-1:0] k4_q;
  reason_e        rsn4_q;
  logic           last4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n00_q   <= 64'(p13_q[31:0]) * 64'(ap3_q[31:0]);
      n01_q   <= 64'(p13_q[31:0]) * 64'(ap3_q[52:32]);
      n10_q   <= 64'(p13_q[63:32]) * 64'(ap3_q[31:0]);
      n11_q   <= 64'(p13_q[63:32]) * 64'(ap3_q[52:32]);
      dl4_q   <= 51'(ss3_q[31:0]) * 51'(PI_SCALED);
      dh4_q   <= 51'(ss3_q[63:32]) * 51'(PI_SCALED);
      k4_q    <= k3_q;
      rsn4_q  <= rsn3_q;
      last4_q <= last3_q;
    end
  end

  // Stage 5: assemble the wide operands; the shift undoes the direction reduction.
  logic [DIV_W-1:0] num5_q, den5_q;
  reason_e          rsn5_q;
  logic             last5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num5_q  <= DIV_W'(n00_q) + (DIV_W'(n01_q) << 32) + (DIV_W'(n10_q) << 32)
               + (DIV_W'(n11_q) << 64);
      den5_q  <= ((DIV_W'(dh4_q) << 32) + DIV_W'(dl4_q)) << {k4_q, 1'b0};
      rsn5_q  <= rsn4_q;
      last5_q <= last4_q;
    end
  end

  // Saturation check, then one restoring quotient bit per stage, most significant first.
  logic [DIV_W-1:0] rem_q [DIV_STEPS+1];
  logic [DIV_W-1:0] den_q [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_q [DIV_STEPS+1];
  logic             sat_q [DIV_STEPS+1];
  reason_e          rsn_q [DIV_STEPS+1];
  logic             last_q [DIV_STEPS+1];
  logic [DIV_W-1:0] rem_d [DIV_STEPS];
  logic [QUO_W-1:0] quo_d [DIV_STEPS];
  logic             sat5;

  assign sat5 = ((den5_q >> (DIV_W - QUO_W)) == '0) && (num5_q >= (den5_q << QUO_W));

  always_comb begin
    int               sh;
    logic [DIV_W-1:0] t;
    logic             ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      sh = DIV_STEPS - 1 - j;
      t  = den_q[j] << sh;
      // A shifted divisor that would overflow the word is larger than any numerator.
      ge = ((den_q[j] >> (DIV_W - sh)) == '0) && (rem_q[j] >= t);
      rem_d[j] = ge ? rem_q[j] - t : rem_q[j];
      quo_d[j] = quo_q[j] | (QUO_W'(ge) << sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= num5_q;
      den_q[0]  <= den5_q;
      quo_q[0]  <= '0;
      sat_q[0]  <= sat5;
      rsn_q[0]  <= rsn5_q;
      last_q[0] <= last5_q;
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_q[j+1]  <= rem_d[j];
        den_q[j+1]  <= den_q[j];
        quo_q[j+1]  <= quo_d[j];
        sat_q[j+1]  <= sat_q[j];
        rsn_q[j+1]  <= rsn_q[j];
        last_q[j+1] <= last_q[j];
      end
    end
  end

  always_comb begin
    if (rsn_q[DIV_STEPS] != REASON_OK) begin
      res_o.form_factor = '0;
    end else if (sat_q[DIV_STEPS]) begin
      res_o.form_factor = FF_ONE;
    end else begin
      res_o.form_factor = {1'b0, quo_q[DIV_STEPS]};
    end
  end

  assign res_o.valid         = vld_q[NSTG-1];
  assign res_o.reject_reason = rsn_q[DIV_STEPS];
  assign res_o.last_out      = last_q[DIV_STEPS];

  `FFS_ASSERT(a_reject_is_zero, res_o.valid && res_o.reject_reason != REASON_OK |-> res_o.form_factor == '0, "rejected pair with non-zero form factor")
  `FFS_ASSERT(a_ff_saturated, res_o.valid |-> res_o.form_factor <= FF_ONE, "form factor above one")

endmodule
`default_nettype wire

// ===== src/form_factor_stream_unit.sv =====
// Form factor stream unit: differential-area form factor of target patches
// seen from one source patch.
// Channels: cfg_i writes the source position (indices 0 to 2) and normal
// (indices 3 to 5); it is always ready and other indices are dropped. Write it
// only while no transaction is in flight. tgt_i carries one target patch per
// transaction, res_o returns one result per target in the same order.
// Throughput: one target per cycle, sustained while res_o keeps up.
// Path: a target passes the 3-stage front, the queue and the 22-stage back
// (6 arithmetic stages and 16 quotient stages) before its result can be
// taken on res_o.
// Stalls: when res_o is not ready the back pipeline holds; the front keeps
// accepting until the queue is committed, then tgt_i drops ready.
// Reset: clears the queue and pipeline valids; the source position goes to
// the origin and the source normal to +z.
`default_nettype none
module form_factor_stream_unit import ffs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffs_cfg_if.sink   cfg_i,
  ffs_tgt_if.sink   tgt_i,
  ffs_res_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pos_x: '0, pos_y: '0, pos_z: '0, norm_x: '0, norm_y: '0,
                 norm_z: NORM_Z_RESET};
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_POS_X:  cfg_q.pos_x  <= cfg_i.data;
        REG_POS_Y:  cfg_q.pos_y  <= cfg_i.data;
        REG_POS_Z:  cfg_q.pos_z  <= cfg_i.data;
        REG_NORM_X: cfg_q.norm_x <= cfg_i.data[15:0];
        REG_NORM_Y: cfg_q.norm_y <= cfg_i.data[15:0];
        REG_NORM_Z: cfg_q.norm_z <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  logic             push;
  work_t            push_data;
  logic             pop;
  logic             head_valid;
  work_t            head;
  logic [CNT_W-1:0] q_count;

  ffs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tgt_i       (tgt_i),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ffs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  ffs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
module tb;
  import ffs_pkg::*;

  typedef struct {
    logic [16:0] ff;
    reason_e     reason;
    logic        last;
  } ff_result_t;

  // Holds the source patch, predicts each target's result and checks results in order.
  class ff_scoreboard;
    logic signed [31:0] src_pos [3];
    logic signed [15:0] src_norm [3];
    ff_result_t pending [$];
    int mismatches;
    int checked;
    int n_ok, n_near, n_back, n_sat;

    function void reset_regs();
      src_pos = '{0, 0, 0};
      src_norm = '{0, 0, 16384};
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      if (idx <= REG_POS_Z) src_pos[idx] = val;
      else if (idx <= REG_NORM_Z) src_norm[idx - REG_NORM_X] = val[15:0];
    endfunction

    function ff_result_t predict(logic signed [31:0] tp [3], logic signed [15:0] tn [3],
                                 logic [31:0] area, logic last);
      ff_result_t r;
      longint d [3];
      longint e [3];
      longint a, b, ar, br, mx, q;
      logic [63:0] sred;
      logic [255:0] num, den;
      int k;
      a = 0; b = 0; ar = 0; br = 0; mx = 0; sred = 0; k = 0;
      r.ff = '0;
      r.reason = REASON_OK;
      r.last = last;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(tp[i]) - longint'(src_pos[i]);
        if ((d[i] < 0 ? -d[i] : d[i]) > mx) mx = d[i] < 0 ? -d[i] : d[i];
        a += longint'(src_norm[i]) * d[i];
        b -= longint'(tn[i]) * d[i];
      end
      if (mx < 65536 && d[0]*d[0] + d[1]*d[1] + d[2]*d[2] < 4295) begin
        r.reason = REASON_NEAR;
      end else if (a <= 0 || b <= 0) begin
        r.reason = REASON_BACK;
      end else begin
        while ((mx >> k) >= 32768) k++;
        for (int i = 0; i < 3; i++) begin
          q = (d[i] < 0 ? -d[i] : d[i]) >> k;
          e[i] = d[i] < 0 ? -q : q;
          sred += q * q;
          ar += longint'(src_norm[i]) * e[i];
          br -= longint'(tn[i]) * e[i];
        end
        if (ar < 0) ar = 0;
        if (br < 0) br = 0;
        num = 256'(ar) * 256'(br) * 256'(area) * 256'd1600000;
        den = (256'(sred) * 256'(sred) * 256'd314159) << (2 * k);
        num = num / den;
        r.ff = (num >= 65536) ? 17'd65536 : num[16:0];
        if (r.ff == 17'd65536) n_sat++;
      end
      if (r.reason == REASON_OK) n_ok++;
      else if (r.reason == REASON_NEAR) n_near++;
      else n_back++;
      return r;
    endfunction

    function void note_target(logic signed [31:0] tp [3], logic signed [15:0] tn [3],
                              logic [31:0] area, logic last);
      pending.insert(pending.size(), predict(tp, tn, area, last));
    endfunction

    function void check_result(logic [16:0] ff, logic [1:0] reason, logic last);
      ff_result_t x;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result ff=%0d reason=%0d", ff, reason);
        return;
      end
      x = pending.pop_front();
      if (ff !== x.ff || reason !== x.reason || last !== x.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected ff=%0d reason=%0d last=%0b, got ff=%0d reason=%0d last=%0b",
                   x.ff, x.reason, x.last, ff, reason, last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  ffs_cfg_if cfg_if ();
  ffs_tgt_if tgt_if ();
  ffs_res_if res_if ();

  form_factor_stream_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .tgt_i (tgt_if.sink),
    .res_o (res_if.source)
  );

  ff_scoreboard form_sb;
  int hold_cycles;
  bit sink_random;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, or a long counted hold-off when asked.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready)
        form_sb.check_result(res_if.form_factor, res_if.reject_reason, res_if.last_out);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else if (sink_random) begin
        res_if.ready <= ($urandom_range(0, 99) < 70);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    form_sb.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    tgt_if.valid <= 1'b0;
    while (form_sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_target(logic signed [31:0] tp [3], logic signed [15:0] tn [3],
                             logic [31:0] area, logic last, bit gaps);
    int g;
    tgt_if.valid <= 1'b1;
    tgt_if.target_pos_x <= tp[0];
    tgt_if.target_pos_y <= tp[1];
    tgt_if.target_pos_z <= tp[2];
    tgt_if.target_norm_x <= tn[0];
    tgt_if.target_norm_y <= tn[1];
    tgt_if.target_norm_z <= tn[2];
    tgt_if.target_area <= area;
    tgt_if.last_in <= last;
    do @(posedge clk_i); while (!tgt_if.ready);
    form_sb.note_target(tp, tn, area, last);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      tgt_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] rand_norm();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'sd16384;
    if (p == 1) return -16'sd16384;
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  function automatic logic signed [31:0] rand_coord(logic signed [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return base + $signed(32'($urandom_range(0, 200))) - 32'sd100;
      2: return base + $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
      default: return base + $signed(32'($urandom_range(0, 1 << 24))) - 32'sd8388608;
    endcase
  endfunction

  task automatic random_target(bit gaps);
    logic signed [31:0] tp [3];
    logic signed [15:0] tn [3];
    logic [31:0] area;
    for (int i = 0; i < 3; i++) begin
      tp[i] = rand_coord(form_sb.src_pos[i]);
      tn[i] = rand_norm();
    end
    // Face the target back towards the source most of the time.
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < 3; i++) tn[i] = -form_sb.src_norm[i];
    area = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    send_target(tp, tn, area, $urandom_range(0, 1), gaps);
  endtask

  task automatic random_source();
    write_cfg(REG_POS_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22));
    write_cfg(REG_POS_Y, $urandom);
    write_cfg(REG_POS_Z, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
    write_cfg(REG_NORM_X, 32'(rand_norm()));
    write_cfg(REG_NORM_Y, 32'(rand_norm()));
    write_cfg(REG_NORM_Z, 32'(rand_norm()));
  endtask

  initial begin
    logic signed [31:0] tp [3];
    logic signed [15:0] tn [3];
    form_sb = new();
    form_sb.reset_regs();
    hold_cycles = 0;
    sink_random = 1'b0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    tgt_if.valid = 1'b0;
    tgt_if.target_pos_x = '0;
    tgt_if.target_pos_y = '0;
    tgt_if.target_pos_z = '0;
    tgt_if.target_norm_x = '0;
    tgt_if.target_norm_y = '0;
    tgt_if.target_norm_z = '0;
    tgt_if.target_area = '0;
    tgt_if.last_in = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset source: near, back facing, saturated, small.
    tp = '{0, 0, 0}; tn = '{0, 0, -16384};
    send_target(tp, tn, 32'hffff_ffff, 1'b1, 0);
    tp = '{0, 0, 65}; send_target(tp, tn, 32'h0001_0000, 1'b0, 0);
    tp = '{0, 0, 66}; send_target(tp, tn, 32'h0001_0000, 1'b0, 0);
    tp = '{0, 0, 32'sh0001_0000}; send_target(tp, tn, 32'hffff_ffff, 1'b1, 0);
    tp = '{0, 0, 32'sh7fff_ffff}; send_target(tp, tn, 32'hffff_ffff, 1'b0, 0);
    tp = '{0, 0, 32'sh7fff_ffff}; send_target(tp, tn, 32'h0000_0001, 1'b0, 0);
    tp = '{0, 0, -32'sh0001_0000}; send_target(tp, tn, 32'h0001_0000, 1'b0, 0);
    tn = '{0, 0, 16384}; tp = '{0, 0, 32'sh0001_0000};
    send_target(tp, tn, 32'h0001_0000, 1'b0, 0);
    tn = '{16384, -16384, -16384}; tp = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0100_0000};
    send_target(tp, tn, 32'h0000_0000, 1'b1, 0);
    tn = '{-16384, 16384, -16384}; tp = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001};
    send_target(tp, tn, 32'hffff_ffff, 1'b0, 0);
    // A nearly grazing direction whose cosine vanishes after the reduction.
    tn = '{0, 0, -16384}; tp = '{32'sh7fff_ffff, 0, 1};
    send_target(tp, tn, 32'hffff_ffff, 1'b0, 0);
    wait_drained();

    // Extreme source, every register written by name.
    write_cfg(REG_POS_X, 32'h8000_0000);
    write_cfg(REG_POS_Y, 32'h7fff_ffff);
    write_cfg(REG_POS_Z, 32'h0000_0000);
    write_cfg(REG_NORM_X, 32'(-16'sd16384));
    write_cfg(REG_NORM_Y, 32'(16'sd16384));
    write_cfg(REG_NORM_Z, 32'(16'sd0));
    tp = '{32'sh7fff_ffff, 32'sh8000_0000, 0}; tn = '{16384, -16384, 0};
    send_target(tp, tn, 32'hffff_ffff, 1'b1, 0);
    tp = '{32'sh8000_0000, 32'sh7fff_ffff, 0};
    send_target(tp, tn, 32'h1234_5678, 1'b0, 0);
    tp = '{32'sh8000_1000, 32'sh7fff_f000, 100}; tn = '{-16384, 16384, 0};
    send_target(tp, tn, 32'hffff_ffff, 1'b1, 0);
    for (int i = 0; i < 8; i++) random_target(0);
    wait_drained();

    // Random phases under a range of source settings.
    sink_random = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      random_source();
      for (int n = 0; n < 200; n++) random_target(n % 100 > 30);
      if (ph == 2) begin
        // Long receiver hold-off while targets keep coming.
        hold_cycles = 120;
        for (int n = 0; n < 60; n++) random_target(0);
      end
      wait_drained();
    end

    write_cfg(REG_POS_X, 32'h0);
    write_cfg(REG_POS_Y, 32'h0);
    write_cfg(REG_POS_Z, 32'h0);
    write_cfg(REG_NORM_X, 32'h0);
    write_cfg(REG_NORM_Y, 32'h0);
    write_cfg(REG_NORM_Z, 32'(16'sd16384));
    for (int n = 0; n < 25; n++) random_target(1);
    wait_drained();

    $display("Covered %0d targets: %0d computed (%0d saturated), %0d too close, %0d back facing.",
             form_sb.checked, form_sb.n_ok, form_sb.n_sat, form_sb.n_near, form_sb.n_back);
    $display("Mismatches found: %0d.", form_sb.mismatches);
    if (form_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/ffs_pkg.sv
src/ffs_if.sv
src/ffs_front.sv
src/ffs_queue.sv
src/ffs_back.sv
src/form_factor_stream_unit.sv
test/tb.sv
